// ===== rtl/mwrs_pkg.sv =====
// Shared types and constants for the Microwire EEPROM read sequencer.
// Used by the top level and by its port checker; no dependencies.
`timescale 1ns / 1ps

package mwrs_pkg;

   localparam int WORD_BITS        = 16;
   localparam int CMD_BITS         = 13;
   localparam int NARROW_ADDR_BITS = 6;
   localparam int WIDE_ADDR_BITS   = 8;

   localparam logic [2:0] READ_OPCODE = 3'd6;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] location;
      logic       wide_address;
      logic       eeprom_do;
   } req_word_type;

   typedef struct packed {
      logic                 chip_select;
      logic                 shift_clock;
      logic                 data_to_eeprom;
      logic                 busy_res;
      logic                 read_done;
      logic [WORD_BITS-1:0] read_word;
      logic                 request_ignored;
   } rsp_word_type;

endpackage

// ===== rtl/microwire_eeprom_read_sequencer_unit.sv =====
// Each accepted word's result is registered in the result register, or in the skid register.
// Throughput: one word per cycle; a skid register takes one more word while
// the result register is stalled, then req_stall rises.
// A full read takes 2 + 2*(5+width) + 1 + 2*DATA_BITS + 1 tick words.
// Reset (synchronous): sequencer idle, pins low, result and skid registers empty.
`timescale 1ns / 1ps

module microwire_eeprom_read_sequencer_unit #(
   parameter int DATA_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mwrs_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mwrs_pkg::rsp_word_type rsp_word
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CS_LOW,
      PH_CS_HIGH,
      PH_CMD,
      PH_SETTLE,
      PH_DATA,
      PH_DESELECT
   } phase_type;

   phase_type                         phase_ff,         phase_in;
   logic [4:0]                        bit_counter_ff,   bit_counter_in;
   logic                              half_step_ff,     half_step_in;
   logic [mwrs_pkg::CMD_BITS-1:0]     command_shift_ff, command_shift_in;
   logic [mwrs_pkg::WORD_BITS-1:0]    data_shift_ff,    data_shift_in;
   logic                              cs_ff,            cs_in;
   logic                              clk_ff,           clk_in;
   logic                              di_ff,            di_in;

   logic                              out_valid_ff;
   logic                              skid_valid_ff;
   mwrs_pkg::rsp_word_type            out_ff;
   mwrs_pkg::rsp_word_type            skid_ff;
   mwrs_pkg::rsp_word_type            result;

   logic                              req_accept;
   logic                              rsp_take;
   logic [15:0]                       cmd_ext;
   logic                              cmd_bit;
   logic                              done;
   logic                              ignored;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;
   assign rsp_word   = out_ff;

   assign cmd_ext = 16'(command_shift_ff);
   assign cmd_bit = cmd_ext[bit_counter_ff[3:0]];

   always_comb begin
      phase_in         = phase_ff;
      bit_counter_in   = bit_counter_ff;
      half_step_in     = half_step_ff;
      command_shift_in = command_shift_ff;
      data_shift_in    = data_shift_ff;
      cs_in            = cs_ff;
      clk_in           = clk_ff;
      di_in            = di_ff;
      done             = 1'b0;
      ignored          = 1'b0;

      if (req_word.req_type == mwrs_pkg::REQ_START) begin
         if (phase_ff != PH_IDLE) begin
            ignored = 1'b1;
         end else begin
            if (req_word.wide_address) begin
               command_shift_in = mwrs_pkg::CMD_BITS'(req_word.location)
                  | (mwrs_pkg::CMD_BITS'(mwrs_pkg::READ_OPCODE) << mwrs_pkg::WIDE_ADDR_BITS);
               bit_counter_in   = 5'(4 + mwrs_pkg::WIDE_ADDR_BITS);
            end else begin
               command_shift_in = mwrs_pkg::CMD_BITS'(req_word.location)
                  | (mwrs_pkg::CMD_BITS'(mwrs_pkg::READ_OPCODE) << mwrs_pkg::NARROW_ADDR_BITS);
               bit_counter_in   = 5'(4 + mwrs_pkg::NARROW_ADDR_BITS);
            end
            half_step_in  = 1'b0;
            data_shift_in = '0;
            phase_in      = PH_CS_LOW;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_CS_LOW: begin
               cs_in    = 1'b0;
               clk_in   = 1'b0;
               di_in    = 1'b0;
               phase_in = PH_CS_HIGH;
            end
            PH_CS_HIGH: begin
               cs_in        = 1'b1;
               clk_in       = 1'b0;
               di_in        = 1'b0;
               half_step_in = 1'b0;
               phase_in     = PH_CMD;
            end
            PH_CMD: begin
               cs_in = 1'b1;
               di_in = cmd_bit;
               if (!half_step_ff) begin
                  clk_in       = 1'b0;
                  half_step_in = 1'b1;
               end else begin
                  clk_in       = 1'b1;
                  half_step_in = 1'b0;
                  if (bit_counter_ff == '0) begin
                     phase_in = PH_SETTLE;
                  end else begin
                     bit_counter_in = bit_counter_ff - 5'd1;
                  end
               end
            end
            PH_SETTLE: begin
               cs_in          = 1'b1;
               clk_in         = 1'b0;
               di_in          = 1'b0;
               bit_counter_in = 5'(DATA_BITS - 1);
               half_step_in   = 1'b0;
               phase_in       = PH_DATA;
            end
            PH_DATA: begin
               cs_in = 1'b1;
               di_in = 1'b0;
               if (!half_step_ff) begin
                  clk_in       = 1'b1;
                  half_step_in = 1'b1;
               end else begin
                  clk_in        = 1'b0;
                  half_step_in  = 1'b0;
                  data_shift_in = {data_shift_ff[mwrs_pkg::WORD_BITS-2:0],
                                   req_word.eeprom_do};
                  if (bit_counter_ff == '0) begin
                     phase_in = PH_DESELECT;
                  end else begin
                     bit_counter_in = bit_counter_ff - 5'd1;
                  end
               end
            end
            PH_DESELECT: begin
               cs_in    = 1'b0;
               clk_in   = 1'b0;
               di_in    = 1'b0;
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      result.chip_select     = cs_in;
      result.shift_clock     = clk_in;
      result.data_to_eeprom  = di_in;
      result.busy_res        = (phase_in != PH_IDLE);
      result.read_done       = done;
      result.read_word       = done ? data_shift_ff : '0;
      result.request_ignored = ignored;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_counter_ff   <= '0;
         half_step_ff     <= 1'b0;
         command_shift_ff <= '0;
         data_shift_ff    <= '0;
         cs_ff            <= 1'b0;
         clk_ff           <= 1'b0;
         di_ff            <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff         <= phase_in;
            bit_counter_ff   <= bit_counter_in;
            half_step_ff     <= half_step_in;
            command_shift_ff <= command_shift_in;
            data_shift_ff    <= data_shift_in;
            cs_ff            <= cs_in;
            clk_ff           <= clk_in;
            di_ff            <= di_in;
         end
         if (rsp_take || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_ff       <= result;
               out_valid_ff <= req_accept;
            end
         end else if (req_accept) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

// ===== rtl/mwrs_checker.sv =====
// Port-level checks for the Microwire EEPROM read sequencer, bound to the top level.
// Depends on mwrs_pkg and microwire_eeprom_read_sequencer_unit.
`timescale 1ns / 1ps

module mwrs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input mwrs_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mwrs_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result not empty after reset");

   a_ignored_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.request_ignored |-> rsp_word.busy_res)
      else $error("start dropped while not busy");

   a_done_deselect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.read_done
         |-> !rsp_word.busy_res && !rsp_word.chip_select && !rsp_word.shift_clock)
      else $error("read finished with chip still selected");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.read_done |-> rsp_word.read_word == '0)
      else $error("read word shown outside completion");

endmodule

bind microwire_eeprom_read_sequencer_unit mwrs_checker u_mwrs_checker (.*);

// ===== tb/tb_microwire_eeprom_read_sequencer_unit.sv =====
// Self-checking testbench for the Microwire EEPROM read sequencer: directed and random
// read sequences, compared word by word against a behavioral model of the pin stepping.
// Depends on mwrs_pkg and microwire_eeprom_read_sequencer_unit.
`timescale 1ns / 1ps

module tb_microwire_eeprom_read_sequencer_unit;

   localparam int DATA_BITS = mwrs_pkg::WORD_BITS;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_CS_LOW, SEQ_CS_HIGH, SEQ_COMMAND, SEQ_SETTLE, SEQ_DATA, SEQ_DESELECT
   } seq_phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   mwrs_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   mwrs_pkg::rsp_word_type rsp_word;

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int step_count     = 0;

   mwrs_pkg::rsp_word_type expected_rsp[$];

   // pin-stepping model state
   seq_phase_type seq_phase    = SEQ_IDLE;
   logic [4:0]    bits_left    = '0;
   logic          clock_high   = 1'b0;
   logic [12:0]   command_bits = '0;
   logic [15:0]   captured     = '0;
   logic          pin_cs = 1'b0, pin_sk = 1'b0, pin_di = 1'b0;

   microwire_eeprom_read_sequencer_unit #(.DATA_BITS(DATA_BITS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic mwrs_pkg::rsp_word_type eeprom_pin_step(mwrs_pkg::req_word_type w);
      mwrs_pkg::rsp_word_type r;
      int                     addr_bits;
      r = '0;
      if (w.req_type == mwrs_pkg::REQ_START) begin
         if (seq_phase != SEQ_IDLE) begin
            r.request_ignored = 1'b1;
         end else begin
            addr_bits    = w.wide_address ? mwrs_pkg::WIDE_ADDR_BITS
                                          : mwrs_pkg::NARROW_ADDR_BITS;
            command_bits = 13'(w.location) | (13'(mwrs_pkg::READ_OPCODE) << addr_bits);
            bits_left    = 5'(4 + addr_bits);
            clock_high   = 1'b0;
            captured     = '0;
            seq_phase    = SEQ_CS_LOW;
         end
      end else begin
         case (seq_phase)
            SEQ_CS_LOW: begin
               {pin_cs, pin_sk, pin_di} = 3'b000;
               seq_phase = SEQ_CS_HIGH;
            end
            SEQ_CS_HIGH: begin
               {pin_cs, pin_sk, pin_di} = 3'b100;
               clock_high = 1'b0;
               seq_phase  = SEQ_COMMAND;
            end
            SEQ_COMMAND: begin
               pin_cs = 1'b1;
               pin_sk = clock_high;
               pin_di = command_bits[bits_left];
               if (!clock_high) begin
                  clock_high = 1'b1;
               end else begin
                  clock_high = 1'b0;
                  if (bits_left == 0) seq_phase = SEQ_SETTLE;
                  else bits_left = bits_left - 5'd1;
               end
            end
            SEQ_SETTLE: begin
               {pin_cs, pin_sk, pin_di} = 3'b100;
               bits_left  = 5'(DATA_BITS - 1);
               clock_high = 1'b0;
               seq_phase  = SEQ_DATA;
            end
            SEQ_DATA: begin
               if (!clock_high) begin
                  {pin_cs, pin_sk, pin_di} = 3'b110;
                  clock_high = 1'b1;
               end else begin
                  {pin_cs, pin_sk, pin_di} = 3'b100;
                  clock_high = 1'b0;
                  captured   = {captured[14:0], w.eeprom_do};
                  if (bits_left == 0) seq_phase = SEQ_DESELECT;
                  else bits_left = bits_left - 5'd1;
               end
            end
            SEQ_DESELECT: begin
               {pin_cs, pin_sk, pin_di} = 3'b000;
               r.read_done = 1'b1;
               r.read_word = captured;
               seq_phase   = SEQ_IDLE;
            end
            default: seq_phase = SEQ_IDLE;
         endcase
      end
      r.chip_select    = pin_cs;
      r.shift_clock    = pin_sk;
      r.data_to_eeprom = pin_di;
      r.busy_res       = (seq_phase != SEQ_IDLE);
      return r;
   endfunction

   function automatic mwrs_pkg::req_word_type random_word(logic kind);
      mwrs_pkg::req_word_type w;
      w.req_type     = kind;
      w.location     = 8'($urandom);
      w.wide_address = 1'($urandom);
      w.eeprom_do    = 1'($urandom);
      return w;
   endfunction

   task automatic check_field(input string field_name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      mwrs_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("result word with none expected");
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("chip_select", want.chip_select, rsp_word.chip_select);
            check_field("shift_clock", want.shift_clock, rsp_word.shift_clock);
            check_field("data_to_eeprom", want.data_to_eeprom, rsp_word.data_to_eeprom);
            check_field("busy_res", want.busy_res, rsp_word.busy_res);
            check_field("read_done", want.read_done, rsp_word.read_done);
            check_field("read_word", want.read_word, rsp_word.read_word);
            check_field("request_ignored", want.request_ignored, rsp_word.request_ignored);
         end
      end
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   task automatic send_word(input mwrs_pkg::req_word_type w);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(eeprom_pin_step(w));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // one full read; noise_pct inserts starts while busy
   task automatic run_read(input logic [7:0] loc, input logic wide, input logic [15:0] pattern,
                           input int noise_pct);
      mwrs_pkg::req_word_type w;
      w = random_word(mwrs_pkg::REQ_START);
      w.location     = loc;
      w.wide_address = wide;
      send_word(w);
      step_count++;
      while (seq_phase != SEQ_IDLE) begin
         if ($urandom_range(99) < noise_pct) send_word(random_word(mwrs_pkg::REQ_START));
         w = random_word(mwrs_pkg::REQ_TICK);
         if (seq_phase == SEQ_DATA && clock_high) w.eeprom_do = pattern[bits_left[3:0]];
         send_word(w);
         step_count++;
      end
   endtask

   task automatic test_idle_ticks();
      mwrs_pkg::req_word_type w;
      w = '{req_type: mwrs_pkg::REQ_TICK, location: 8'h00, wide_address: 1'b0,
            eeprom_do: 1'b0};
      send_word(w);
      w = '{req_type: mwrs_pkg::REQ_TICK, location: 8'hFF, wide_address: 1'b1,
            eeprom_do: 1'b1};
      send_word(w);
      send_word(random_word(mwrs_pkg::REQ_TICK));
   endtask

   task automatic test_narrow_reads();
      run_read(8'h00, 1'b0, 16'hFFFF, 0);
      run_read(8'h3F, 1'b0, 16'h0000, 0);
   endtask

   task automatic test_wide_read();
      run_read(8'hFF, 1'b1, 16'hA5C3, 0);
   endtask

   task automatic test_narrow_high_location();
      run_read(8'hC5, 1'b0, 16'h8001, 0);
   endtask

   task automatic test_start_while_busy();
      run_read(8'h5A, 1'b1, 16'h1234, 100);
      wait_for_results();
   endtask

   task automatic test_random_reads(input int send_pct, input int recv_pct, input int goal);
      int stop_at;
      send_gap_pct   = send_pct;
      recv_stall_pct = recv_pct;
      stop_at        = step_count + goal;
      while (step_count < stop_at) begin
         if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 3)) send_word(random_word(mwrs_pkg::REQ_TICK));
         run_read(8'($urandom), 1'($urandom), 16'($urandom),
                  $urandom_range(1) ? 0 : 6);
      end
      wait_for_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct   = 22;
      recv_stall_pct = 48;
      test_idle_ticks();
      test_narrow_reads();
      test_wide_read();
      test_narrow_high_location();
      test_start_while_busy();
      test_random_reads(22, 48, 500);
      test_random_reads(48, 22, 500);
      test_random_reads(0, 0, 500);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
